// ===== src/lfpa_pkg.sv =====
package lfpa_pkg;

   localparam int SUM_W = 20;
   localparam int WORD_W = 16;
   localparam logic [7:0] HDR_BYTE = 8'h59;
   localparam logic [7:0] CSUM_SEED = 8'hB2;
   localparam logic [WORD_W-1:0] WORD_MAX = 16'hFFFF;
   localparam logic [WORD_W-1:0] MIN_STRENGTH_RESET = 16'd100;
   localparam logic [0:0] REG_MIN_STRENGTH = 1'b0;

   typedef enum logic [3:0] {
      POS_HDR0 = 4'd0,
      POS_HDR1 = 4'd1,
      POS_DIST_LO = 4'd2,
      POS_DIST_HI = 4'd3,
      POS_STR_LO = 4'd4,
      POS_STR_HI = 4'd5,
      POS_SPARE0 = 4'd6,
      POS_SPARE1 = 4'd7,
      POS_CSUM = 4'd8
   } pos_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_CHECKSUM = 2'd1,
      ST_WEAK = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SUM,
      S_DIV,
      S_EMIT
   } state_type;

endpackage

// ===== src/lfpa_ram.sv =====
module lfpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 5,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lfpa_div.sv =====
module lfpa_div
   import lfpa_pkg::*;
#(
   parameter int DIV_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? DIV_W'(shifted - {1'b0, dvs_ff}) : DIV_W'(shifted);
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/lidar_frame_parser_averager.sv =====
// Channel  Direction  Ports       Fields, lowest bit first
// req      in         req_t*      tdata: rx_byte; tuser: restart
// rsp      out        rsp_t*      tdata: avg_distance, raw_distance, signal_strength;
//                                 tuser: status, valid_res
// csr      in/out     csr_p*      APB, min_strength at byte address 0
// Every byte that does not end a frame leaves the block idle and ready for the next byte.
// A frame that is accepted into the average passes through the accepting state, the
// running sum update, the 20-step bit-serial divider and the result load.
// A rejected frame skips the sum and divider; the result register frees the input side.
// Reset is synchronous and needs no clearing pass; a stalled rsp holds the next frame end.
module lidar_frame_parser_averager
   import lfpa_pkg::*;
#(
   parameter int WINDOW = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // avg_distance, raw_distance, signal_strength
   output logic [2:0]  rsp_tuser,   // status, valid_res
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   state_type         state_ff, state_in;
   logic [3:0]        pos_ff, pos_in;
   logic [7:0]        csum_ff, csum_in;
   logic [WORD_W-1:0] dist_ff, dist_in;
   logic [WORD_W-1:0] str_ff, str_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] min_str_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              full_ff, full_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_avg_ff, rsp_dist_ff, rsp_str_ff;
   status_type        rsp_status_ff;
   logic              rsp_ok_ff;

   logic              req_fire, frame_end, frame_good;
   logic              mem_wr, div_start, rsp_load;
   logic [WORD_W-1:0] old_sample;
   logic [CNT_W-1:0]  count;
   logic              div_done;
   logic [SUM_W-1:0]  quotient;
   logic [3:0]        pos_eff;
   status_type        status_chk;

   assign req_fire = req_tvalid && req_tready;
   assign pos_eff = req_tuser ? POS_HDR0 : pos_ff;
   assign frame_end = req_fire && (pos_eff == POS_CSUM);

   always_comb begin
      if (csum_ff != req_tdata) begin
         status_chk = ST_CHECKSUM;
      end else if (str_ff < min_str_ff) begin
         status_chk = ST_WEAK;
      end else if ((str_ff == WORD_MAX) || (dist_ff == WORD_MAX)) begin
         status_chk = ST_SATURATED;
      end else begin
         status_chk = ST_OK;
      end
   end
   assign frame_good = (status_chk == ST_OK);

   always_comb begin
      pos_in = pos_ff;
      csum_in = csum_ff;
      dist_in = dist_ff;
      str_in = str_ff;
      status_in = status_ff;
      if (req_fire) begin
         pos_in = pos_eff + 4'd1;
         csum_in = csum_ff + req_tdata;
         case (pos_eff)
            POS_HDR1: begin
               csum_in = CSUM_SEED;
               pos_in = (req_tdata == HDR_BYTE) ? POS_DIST_LO : POS_HDR0;
            end
            POS_DIST_LO: dist_in = {8'h00, req_tdata};
            POS_DIST_HI: dist_in = {req_tdata, dist_ff[7:0]};
            POS_STR_LO: str_in = {8'h00, req_tdata};
            POS_STR_HI: str_in = {req_tdata, str_ff[7:0]};
            POS_SPARE0, POS_SPARE1: begin
            end
            POS_CSUM: begin
               csum_in = csum_ff;
               pos_in = POS_HDR0;
               status_in = status_chk;
            end
            default: begin
               csum_in = csum_ff;
               pos_in = (req_tdata == HDR_BYTE) ? POS_HDR1 : POS_HDR0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (frame_end) begin
               state_in = frame_good ? S_SUM : S_EMIT;
            end
         end
         S_SUM: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      mem_wr = 1'b0;
      div_start = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_SUM: begin
            mem_wr = 1'b1;
            div_start = 1'b1;
         end
         S_DIV: begin
         end
         S_EMIT: rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      full_in = full_ff;
      sum_in = sum_ff;
      count = CNT_W'(WINDOW);
      if (mem_wr) begin
         sum_in = sum_ff - (full_ff ? SUM_W'(old_sample) : '0) + SUM_W'(dist_ff);
         if (idx_ff == IDX_W'(WINDOW - 1)) begin
            idx_in = '0;
            full_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            count = full_ff ? CNT_W'(WINDOW) : CNT_W'(idx_ff + 1'b1);
         end
      end
   end

   lfpa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(WINDOW),
      .ADDR_W(IDX_W)
   ) u_window (
      .clock(clock),
      .wr_en(mem_wr),
      .wr_addr(idx_ff),
      .wr_data(dist_ff),
      .rd_addr(idx_ff),
      .rd_data(old_sample)
   );

   lfpa_div #(
      .DIV_W(CNT_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(sum_in),
      .divisor(count),
      .done(div_done),
      .quotient(quotient)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= POS_HDR0;
         csum_ff <= '0;
         dist_ff <= '0;
         str_ff <= '0;
         status_ff <= ST_OK;
         min_str_ff <= MIN_STRENGTH_RESET;
         idx_ff <= '0;
         full_ff <= 1'b0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         csum_ff <= csum_in;
         dist_ff <= dist_in;
         str_ff <= str_in;
         status_ff <= status_in;
         idx_ff <= idx_in;
         full_ff <= full_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && (csr_paddr[2] == REG_MIN_STRENGTH)) begin
            min_str_ff <= csr_pwdata[WORD_W-1:0];
         end
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_ok_ff <= (status_ff == ST_OK);
         rsp_avg_ff <= (status_ff == ST_OK) ? quotient[WORD_W-1:0] : '0;
         rsp_dist_ff <= dist_ff;
         rsp_str_ff <= str_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_str_ff, rsp_dist_ff, rsp_avg_ff};
   assign rsp_tuser = {rsp_ok_ff, rsp_status_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MIN_STRENGTH) ? {16'h0000, min_str_ff} : 32'h0;

endmodule

// ===== tb/lidar_frame_parser_averager_tb.sv =====
`timescale 1ns / 1ps

module lidar_frame_parser_averager_tb;
   import lfpa_pkg::*;

   localparam int WIN = 5;
   localparam int SETTLE_CYCLES = 30;
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      status_type  status;
      logic        valid;
      logic [15:0] avg;
      logic [15:0] raw_dist;
      logic [15:0] strength;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // rx_byte
   logic        req_tuser;   // restart
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // avg_distance, raw_distance, signal_strength
   logic [2:0]  rsp_tuser;   // status, valid_res
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Frame parser and window state as the block should hold it.
   pos_type     parse_pos = POS_HDR0;
   logic [7:0]  running_csum = '0;
   logic [15:0] dist_word = '0;
   logic [15:0] str_word = '0;
   logic [15:0] win_store [WIN];
   logic [3:0]  win_index = '0;
   logic        win_full = 1'b0;
   logic [19:0] win_sum = '0;
   logic [15:0] min_str = MIN_STRENGTH_RESET;

   reading_type pending_readings [$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          req_gap_max = 10;
   int          rsp_stall_max = 10;

   lidar_frame_parser_averager #(.WINDOW(WIN)) dut (.*);

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void parse_and_average(input logic [7:0] b, input logic restart);
      reading_type r;
      logic [3:0]  slot;
      int unsigned count;
      logic        in_data;
      in_data = 1'b0;
      if (restart) parse_pos = POS_HDR0;
      case (parse_pos)
         POS_HDR1: begin
            if (b == HDR_BYTE) begin
               parse_pos = POS_DIST_LO;
               running_csum = HDR_BYTE + HDR_BYTE;
            end else begin
               parse_pos = POS_HDR0;
            end
         end
         POS_DIST_LO: begin
            dist_word = {8'h00, b};
            in_data = 1'b1;
         end
         POS_DIST_HI: begin
            dist_word[15:8] = b;
            in_data = 1'b1;
         end
         POS_STR_LO: begin
            str_word = {8'h00, b};
            in_data = 1'b1;
         end
         POS_STR_HI: begin
            str_word[15:8] = b;
            in_data = 1'b1;
         end
         POS_SPARE0, POS_SPARE1: begin
            in_data = 1'b1;
         end
         POS_CSUM: begin
            parse_pos = POS_HDR0;
            r.valid = 1'b0;
            r.avg = '0;
            r.raw_dist = dist_word;
            r.strength = str_word;
            if (running_csum != b) begin
               r.status = ST_CHECKSUM;
            end else if (str_word < min_str) begin
               r.status = ST_WEAK;
            end else if (str_word == WORD_MAX || dist_word == WORD_MAX) begin
               r.status = ST_SATURATED;
            end else begin
               r.status = ST_OK;
               r.valid = 1'b1;
               slot = win_index;
               if (slot >= WIN) slot = '0;
               if (win_full) win_sum = win_sum - win_store[slot];
               win_store[slot] = dist_word;
               win_sum = win_sum + dist_word;
               slot = slot + 1'b1;
               if (slot >= WIN) begin
                  slot = '0;
                  win_full = 1'b1;
               end
               win_index = slot;
               count = win_full ? WIN : slot;
               if (count == 0) count = 1;
               r.avg = 16'(win_sum / count);
            end
            pending_readings.push_back(r);
         end
         default: begin
            parse_pos = (b == HDR_BYTE) ? POS_HDR1 : POS_HDR0;
         end
      endcase
      if (in_data) begin
         running_csum = running_csum + b;
         parse_pos = pos_type'(parse_pos + 1'b1);
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input logic restart);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = b;
      req_tuser = restart;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      parse_and_average(b, restart);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [15:0] dist_val, input logic [15:0] strength,
                             input logic bad_csum, input logic restart_first,
                             input int n_bytes);
      logic [7:0] frame_bytes [9];
      logic [7:0] sum;
      sum = '0;
      frame_bytes[0] = HDR_BYTE;
      frame_bytes[1] = HDR_BYTE;
      frame_bytes[2] = dist_val[7:0];
      frame_bytes[3] = dist_val[15:8];
      frame_bytes[4] = strength[7:0];
      frame_bytes[5] = strength[15:8];
      frame_bytes[6] = 8'($urandom);
      frame_bytes[7] = 8'($urandom);
      for (int i = 0; i < 8; i++) sum = sum + frame_bytes[i];
      frame_bytes[8] = bad_csum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      for (int i = 0; i < n_bytes; i++) send_byte(frame_bytes[i], (i == 0) && restart_first);
   endtask

   task automatic settle_block();
      req_tvalid = 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_min_strength(input logic [15:0] value);
      settle_block();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {REG_MIN_STRENGTH, 2'b00};
      csr_pwdata = {16'h0000, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      min_str = value;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== value) begin
         $error("min_strength: expected %0d, actual %0d", value, csr_prdata[15:0]);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic test_reset_threshold();
      send_frame(16'd1234, 16'd100, 1'b0, 1'b0, 9);
      send_frame(16'd500, 16'd99, 1'b0, 1'b0, 9);
      send_frame(16'd0, 16'd65534, 1'b0, 1'b1, 9);
   endtask

   task automatic test_status_codes();
      send_frame(16'd700, 16'd300, 1'b1, 1'b0, 9);
      send_frame(16'd700, 16'd0, 1'b1, 1'b0, 9);
      send_frame(16'hFFFF, 16'd20, 1'b0, 1'b0, 9);
      send_frame(16'hFFFF, 16'd200, 1'b0, 1'b0, 9);
      send_frame(16'd65534, 16'hFFFF, 1'b0, 1'b0, 9);
   endtask

   task automatic test_header_hunt();
      send_byte(8'h00, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(8'hA6, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_frame(16'd321, 16'd4000, 1'b0, 1'b0, 5);
      send_frame(16'd654, 16'd4000, 1'b0, 1'b1, 9);
   endtask

   task automatic random_traffic(input int n_bytes);
      int          sent;
      int          n;
      logic [15:0] dist_val;
      logic [15:0] strength;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(0, 7) == 0) req_gap_max = (req_gap_max != 0) ? 0 : 10;
         case ($urandom_range(0, 6))
            0: dist_val = 16'hFFFF;
            1: dist_val = 16'h0000;
            2: dist_val = 16'hFFFE;
            default: dist_val = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: strength = 16'hFFFF;
            1: strength = min_str;
            2: strength = min_str - 1'b1;
            3: strength = 16'h0000;
            default: strength = 16'($urandom);
         endcase
         case ($urandom_range(0, 19))
            0: begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            1: begin
               n = $urandom_range(1, 8);
               send_frame(dist_val, strength, 1'b0, $urandom_range(0, 1), n);
               sent += n;
            end
            2, 3: begin
               send_frame(dist_val, strength, 1'b1, $urandom_range(0, 1), 9);
               sent += 9;
            end
            default: begin
               send_frame(dist_val, strength, 1'b0, $urandom_range(0, 3) == 0, 9);
               sent += 9;
            end
         endcase
      end
   endtask

   task automatic test_threshold_extremes();
      write_min_strength(16'h0000);
      random_traffic(200);
      write_min_strength(16'hFFFF);
      random_traffic(120);
      write_min_strength(16'($urandom));
      random_traffic(150);
      write_min_strength(MIN_STRENGTH_RESET);
   endtask

   task automatic test_drain_pause();
      random_traffic(40);
      settle_block();
      random_traffic(40);
   endtask

   task automatic test_random_stream();
      random_traffic(450);
      write_min_strength(16'($urandom_range(0, 2000)));
      random_traffic(450);
   endtask

   // Result side: random stalls per transfer, with stretches of no stall.
   initial begin
      int          stall;
      reading_type want;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_stall_max = (rsp_stall_max != 0) ? 0 : 10;
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_readings.size() == 0) begin
            $error("unexpected result transfer: tdata %h, tuser %h", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tuser[1:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser[1:0]);
               mismatch_count++;
            end
            if (rsp_tuser[2] !== want.valid) begin
               $error("valid_res: expected %0d, actual %0d", want.valid, rsp_tuser[2]);
               mismatch_count++;
            end
            if (rsp_tdata[15:0] !== want.avg) begin
               $error("avg_distance: expected %0d, actual %0d", want.avg, rsp_tdata[15:0]);
               mismatch_count++;
            end
            if (rsp_tdata[31:16] !== want.raw_dist) begin
               $error("raw_distance: expected %0d, actual %0d",
                      want.raw_dist, rsp_tdata[31:16]);
               mismatch_count++;
            end
            if (rsp_tdata[47:32] !== want.strength) begin
               $error("signal_strength: expected %0d, actual %0d",
                      want.strength, rsp_tdata[47:32]);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < WIN; i++) win_store[i] = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_threshold();
      test_status_codes();
      test_header_hunt();
      test_threshold_extremes();
      test_drain_pause();
      test_random_stream();

      settle_block();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
